[src/nscd_pkg.sv]
// nscd_pkg: shared types, character codes and helper functions for the
// nmea sentence checksum deframer; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package nscd_pkg;

    localparam int NSCD_BUFFER_DEPTH = 128;
    localparam int HEADER_LEN        = 5;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_V      = 8'h56;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] HEX_ALPHA = 8'd10;

    localparam logic [1:0] KIND_GGA     = 2'd0;
    localparam logic [1:0] KIND_RMC     = 2'd1;
    localparam logic [1:0] KIND_GSV     = 2'd2;
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;

    localparam logic [1:0] STAT_NONE     = 2'd0;
    localparam logic [1:0] STAT_MATCH    = 2'd1;
    localparam logic [1:0] STAT_MISMATCH = 2'd2;
    localparam logic [1:0] STAT_ABORT    = 2'd3;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_DATA = 2'd1,
        PH_SUM  = 2'd2
    } phase_t;

    typedef struct packed {
        logic       sentence_start;
        logic       data_valid;
        logic [7:0] data_char;
        logic [6:0] data_index;
        logic [1:0] status;
        logic [1:0] sentence_kind;
        logic [7:0] computed_sum;
        logic [7:0] received_sum;
    } result_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_t;

    // expected header character of pattern k at position pos
    function automatic logic [7:0] hdr_char(input logic [1:0] k, input logic [2:0] pos);
        logic [7:0] c;
        c = 8'h00;
        case (pos)
            3'd0: c = CH_G;
            3'd1: c = CH_P;
            3'd2: c = (k == KIND_RMC) ? CH_R : CH_G;
            3'd3: begin
                case (k)
                    KIND_GGA: c = CH_G;
                    KIND_RMC: c = CH_M;
                    default:  c = CH_S;
                endcase
            end
            3'd4: begin
                case (k)
                    KIND_GGA: c = CH_A;
                    KIND_RMC: c = CH_C;
                    default:  c = CH_V;
                endcase
            end
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic hex_t hex_decode(input logic [7:0] ch);
        hex_t h;
        logic [7:0] d;
        h.ok = 1'b1;
        d = 8'h00;
        if (ch inside {[8'h30:8'h39]}) begin
            d = ch - 8'h30;
        end else if (ch inside {[8'h41:8'h46]}) begin
            d = ch - 8'h41 + HEX_ALPHA;
        end else if (ch inside {[8'h61:8'h66]}) begin
            d = ch - 8'h61 + HEX_ALPHA;
        end else begin
            h.ok = 1'b0;
        end
        h.value = d[3:0];
        return h;
    endfunction

endpackage

`default_nettype wire

[src/nscd_step.sv]
// nscd_step: sentence state registers and the per-character update logic
// depends on nscd_pkg
`timescale 1ns / 1ps
`default_nettype none

module nscd_step
    import nscd_pkg::*;
#(
    parameter int BUFFER_DEPTH = NSCD_BUFFER_DEPTH
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       fire,
    input  wire logic [7:0] rx_char,
    output result_t         res
);

    localparam int CNT_W = $clog2(BUFFER_DEPTH);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(BUFFER_DEPTH - 1);
    localparam logic [CNT_W-1:0] HDR_LEN_C = CNT_W'(HEADER_LEN);
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

    phase_t           phase_reg, phase_next;
    logic [7:0]       xor_reg, xor_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [2:0]       match_reg, match_next;
    logic [1:0]       kind_reg, kind_next;
    logic [3:0]       nibble_reg, nibble_next;
    logic             second_reg, second_next;

    hex_t       hex;
    logic [8:0] count_ext;
    logic [1:0] classified;
    logic [7:0] rsum;

    assign hex       = hex_decode(rx_char);
    assign count_ext = 9'(count_reg);
    assign rsum      = {nibble_reg, hex.value};

    always_comb begin
        if (count_reg < HDR_LEN_C) begin
            classified = KIND_UNKNOWN;
        end else if (match_reg[0]) begin
            classified = KIND_GGA;
        end else if (match_reg[1]) begin
            classified = KIND_RMC;
        end else if (match_reg[2]) begin
            classified = KIND_GSV;
        end else begin
            classified = KIND_UNKNOWN;
        end
    end

    // next phase
    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_IDLE: begin
                if (rx_char == CH_DOLLAR) phase_next = PH_DATA;
            end
            PH_DATA: begin
                if (rx_char == CH_STAR) phase_next = PH_SUM;
            end
            PH_SUM: begin
                if (!hex.ok || second_reg) phase_next = PH_IDLE;
            end
            default: phase_next = PH_IDLE;
        endcase
    end

    // result and datapath
    always_comb begin
        res         = '0;
        xor_next    = xor_reg;
        count_next  = count_reg;
        match_next  = match_reg;
        kind_next   = kind_reg;
        nibble_next = nibble_reg;
        second_next = second_reg;
        case (phase_reg)
            PH_IDLE: begin
                if (rx_char == CH_DOLLAR) begin
                    res.sentence_start = 1'b1;
                    xor_next    = '0;
                    count_next  = '0;
                    match_next  = '1;
                    kind_next   = KIND_UNKNOWN;
                    nibble_next = '0;
                    second_next = 1'b0;
                end
            end
            PH_DATA: begin
                if (rx_char == CH_STAR) begin
                    kind_next = classified;
                end else begin
                    if (count_reg < CNT_LIMIT) begin
                        if (count_reg < HDR_LEN_C) begin
                            for (int k = 0; k < 3; k++) begin
                                if (hdr_char(2'(k), count_reg[2:0]) != rx_char) begin
                                    match_next[k] = 1'b0;
                                end
                            end
                        end
                        res.data_valid = 1'b1;
                        res.data_char  = rx_char;
                        res.data_index = count_ext[6:0];
                        count_next     = count_reg + CNT_ONE;
                    end
                    xor_next = xor_reg ^ rx_char;
                end
            end
            PH_SUM: begin
                if (!hex.ok) begin
                    res.status        = STAT_ABORT;
                    res.sentence_kind = kind_reg;
                    res.computed_sum  = xor_reg;
                end else if (!second_reg) begin
                    nibble_next = hex.value;
                    second_next = 1'b1;
                end else begin
                    res.received_sum  = rsum;
                    res.computed_sum  = xor_reg;
                    res.sentence_kind = kind_reg;
                    res.status        = (rsum == xor_reg) ? STAT_MATCH : STAT_MISMATCH;
                    second_next       = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            xor_reg    <= '0;
            count_reg  <= '0;
            match_reg  <= '1;
            kind_reg   <= KIND_UNKNOWN;
            nibble_reg <= '0;
            second_reg <= 1'b0;
        end else if (fire) begin
            phase_reg  <= phase_next;
            xor_reg    <= xor_next;
            count_reg  <= count_next;
            match_reg  <= match_next;
            kind_reg   <= kind_next;
            nibble_reg <= nibble_next;
            second_reg <= second_next;
        end
    end

    a_count_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_LIMIT)
        else $error("character count beyond buffer limit");

    a_finish_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && res.status != STAT_NONE |=> phase_reg == PH_IDLE)
        else $error("finished sentence did not return to idle");

    a_start_data: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && res.sentence_start |=> phase_reg == PH_DATA && xor_reg == 8'h00)
        else $error("sentence start did not clear checksum");

    a_second_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        second_reg |-> phase_reg == PH_SUM || phase_reg == PH_IDLE)
        else $error("second digit flag set outside checksum phase");

endmodule

`default_nettype wire

[src/nscd_out_buf.sv]
// nscd_out_buf: two-entry result buffer between the update logic and the
// result channel; depends on nscd_pkg
`timescale 1ns / 1ps
`default_nettype none

module nscd_out_buf
    import nscd_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    push,
    input  wire result_t push_data,
    output logic         not_full,
    output logic         out_valid,
    input  wire logic    pop,
    output result_t      out_data
);

    result_t    slot0_reg, slot1_reg;
    logic [1:0] count_reg;

    assign not_full  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = slot0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case ({push, pop})
            2'b10: begin
                if (count_reg == 2'd0) slot0_reg <= push_data;
                else slot1_reg <= push_data;
            end
            2'b01: slot0_reg <= slot1_reg;
            2'b11: begin
                if (count_reg == 2'd1) slot0_reg <= push_data;
                else begin
                    slot0_reg <= slot1_reg;
                    slot1_reg <= push_data;
                end
            end
            default: begin
            end
        endcase
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("result buffer count out of range");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == 2'd2 |-> !push)
        else $error("request pushed into full result buffer");

    a_pass_through: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop && count_reg == 2'd0 |=> out_valid && out_data == $past(push_data))
        else $error("request lost in empty result buffer");

endmodule

`default_nettype wire

[src/nmea_sentence_checksum_deframer_core.sv]
// nmea_sentence_checksum_deframer_core: top level of the nmea sentence
// deframer with xor checksum check; depends on nscd_pkg, nscd_step and
// nscd_out_buf
//
// usage
//   input channel s_valid / s_ready / s_rx_char carries one serial character
//   per request. each accepted character gives exactly one result request on
//   the m_ channel: sentence start flag, data character with its index,
//   and on the last checksum digit (or a bad hex digit) the status, the
//   sentence kind, the computed and the received checksum.
//   a result is registered in the result buffer and shown on the m_ ports
//   once it reaches the head slot. one character per cycle while s_ready is
//   high, set by the combinational update of the sentence state between the
//   input edge and the result buffer.
//   a two-entry result buffer parts the two channels: s_ready depends on the
//   buffer fill only, so a stalled receiver holds up to two results before
//   s_ready falls; results are never dropped.
//   reset (aresetn low, synchronous) returns the deframer to idle waiting for
//   '$' and empties the result buffer.
`timescale 1ns / 1ps
`default_nettype none

module nmea_sentence_checksum_deframer_core
    import nscd_pkg::*;
#(
    parameter int BUFFER_DEPTH = NSCD_BUFFER_DEPTH
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_rx_char,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_sentence_start,
    output logic            m_data_valid,
    output logic [7:0]      m_data_char,
    output logic [6:0]      m_data_index,
    output logic [1:0]      m_status,
    output logic [1:0]      m_sentence_kind,
    output logic [7:0]      m_computed_sum,
    output logic [7:0]      m_received_sum
);

    logic    fire;
    logic    pop;
    result_t step_res;
    result_t head;

    assign fire = s_valid && s_ready;
    assign pop  = m_valid && m_ready;

    nscd_step #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .rx_char (s_rx_char),
        .res     (step_res)
    );

    nscd_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (fire),
        .push_data (step_res),
        .not_full  (s_ready),
        .out_valid (m_valid),
        .pop       (pop),
        .out_data  (head)
    );

    assign m_sentence_start = head.sentence_start;
    assign m_data_valid     = head.data_valid;
    assign m_data_char      = head.data_char;
    assign m_data_index     = head.data_index;
    assign m_status         = head.status;
    assign m_sentence_kind  = head.sentence_kind;
    assign m_computed_sum   = head.computed_sum;
    assign m_received_sum   = head.received_sum;

endmodule

`default_nettype wire

[tb/sv/tb_nmea_sentence_checksum_deframer_core.sv]
`timescale 1ns / 1ps
// tb_nmea_sentence_checksum_deframer_core: self-checking testbench that feeds framed and
// broken nmea sentences one character per request and checks every result request
// depends on nscd_pkg and nmea_sentence_checksum_deframer_core

module tb_nmea_sentence_checksum_deframer_core;
    import nscd_pkg::*;

    localparam int ITEMS       = 1650;
    localparam int STAGE_LEN   = 550;
    localparam int PAUSE_AT    = 700;
    localparam int HOLD_AT     = 1300;
    localparam int HOLD_LEN    = 200;
    localparam int TAIL_CYCLES = 8;
    localparam int MAX_REPORTS = 10;

    localparam int SUM_GOOD   = 0;
    localparam int SUM_WRONG  = 1;
    localparam int SUM_BAD_HI = 2;
    localparam int SUM_BAD_LO = 3;

    localparam logic [39:0] HDR_GGA = {CH_G, CH_P, CH_G, CH_G, CH_A};
    localparam logic [39:0] HDR_RMC = {CH_G, CH_P, CH_R, CH_M, CH_C};
    localparam logic [39:0] HDR_GSV = {CH_G, CH_P, CH_G, CH_S, CH_V};

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic [7:0] s_rx_char = 8'h00;
    logic       m_ready   = 1'b0;
    logic       s_ready;
    logic       m_valid;
    logic       m_sentence_start;
    logic       m_data_valid;
    logic [7:0] m_data_char;
    logic [6:0] m_data_index;
    logic [1:0] m_status;
    logic [1:0] m_sentence_kind;
    logic [7:0] m_computed_sum;
    logic [7:0] m_received_sum;

    logic [7:0] char_q[$];
    result_t    expected_results[$];
    result_t    mon_got;
    result_t    mon_want;
    int         n_sent     = 0;
    int         n_recv     = 0;
    int         n_errors   = 0;
    int         gen_count  = 0;
    int         hold_left  = 0;
    logic       pause_done = 1'b0;
    logic       hold_done  = 1'b0;
    logic [7:0] gen_sum    = 8'h00;

    phase_t     nm_phase;
    logic [7:0] nm_xor;
    logic [6:0] nm_count;
    logic [2:0] nm_hdr;
    logic [1:0] nm_kind;
    logic [3:0] nm_hi;
    logic       nm_second;

    nmea_sentence_checksum_deframer_core u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_char        (s_rx_char),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_sentence_start (m_sentence_start),
        .m_data_valid     (m_data_valid),
        .m_data_char      (m_data_char),
        .m_data_index     (m_data_index),
        .m_status         (m_status),
        .m_sentence_kind  (m_sentence_kind),
        .m_computed_sum   (m_computed_sum),
        .m_received_sum   (m_received_sum)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic [7:0] header_byte(input int k, input int pos);
        logic [39:0] w;
        case (k)
            0:       w = HDR_GGA;
            1:       w = HDR_RMC;
            default: w = HDR_GSV;
        endcase
        return w[39 - 8 * pos -: 8];
    endfunction

    function automatic int hex_val(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
        if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
        if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
        return -1;
    endfunction

    function automatic void reset_predictor();
        nm_phase  = PH_IDLE;
        nm_xor    = 8'h00;
        nm_count  = 7'd0;
        nm_hdr    = 3'b111;
        nm_kind   = KIND_UNKNOWN;
        nm_hi     = 4'h0;
        nm_second = 1'b0;
    endfunction

    function automatic logic [1:0] header_kind();
        if (nm_count < HEADER_LEN) return KIND_UNKNOWN;
        if (nm_hdr[0]) return KIND_GGA;
        if (nm_hdr[1]) return KIND_RMC;
        if (nm_hdr[2]) return KIND_GSV;
        return KIND_UNKNOWN;
    endfunction

    // advances the sentence state by one character and gives its result
    function automatic result_t predict_char(input logic [7:0] ch);
        result_t r;
        int      v;
        int      k;
        r = '0;
        case (nm_phase)
            PH_IDLE: begin
                if (ch == CH_DOLLAR) begin
                    r.sentence_start = 1'b1;
                    nm_xor    = 8'h00;
                    nm_count  = 7'd0;
                    nm_hdr    = 3'b111;
                    nm_kind   = KIND_UNKNOWN;
                    nm_hi     = 4'h0;
                    nm_second = 1'b0;
                    nm_phase  = PH_DATA;
                end
            end
            PH_DATA: begin
                if (ch == CH_STAR) begin
                    nm_kind  = header_kind();
                    nm_phase = PH_SUM;
                end else begin
                    if (nm_count < NSCD_BUFFER_DEPTH - 1) begin
                        if (nm_count < HEADER_LEN) begin
                            for (k = 0; k < 3; k++) begin
                                if (header_byte(k, int'(nm_count)) != ch) nm_hdr[k] = 1'b0;
                            end
                        end
                        r.data_valid = 1'b1;
                        r.data_char  = ch;
                        r.data_index = nm_count;
                        nm_count     = nm_count + 7'd1;
                    end
                    nm_xor = nm_xor ^ ch;
                end
            end
            PH_SUM: begin
                v = hex_val(ch);
                if (v < 0) begin
                    r.status        = STAT_ABORT;
                    r.sentence_kind = nm_kind;
                    r.computed_sum  = nm_xor;
                    nm_phase        = PH_IDLE;
                end else if (!nm_second) begin
                    nm_hi     = v[3:0];
                    nm_second = 1'b1;
                end else begin
                    r.received_sum  = {nm_hi, v[3:0]};
                    r.computed_sum  = nm_xor;
                    r.sentence_kind = nm_kind;
                    r.status        = (r.received_sum == nm_xor) ? STAT_MATCH : STAT_MISMATCH;
                    nm_second       = 1'b0;
                    nm_phase        = PH_IDLE;
                end
            end
            default: nm_phase = PH_IDLE;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit lower);
        if (nib < 4'd10) return 8'h30 + nib;
        return (lower ? 8'h61 : 8'h41) + nib - 4'd10;
    endfunction

    function automatic logic [7:0] bad_hex_char();
        logic [7:0] c;
        do c = 8'($urandom_range(255)); while (hex_val(c) >= 0);
        return c;
    endfunction

    function automatic logic [7:0] any_data_char();
        logic [7:0] c;
        do begin
            if ($urandom_range(3) == 0) c = 8'($urandom_range(255));
            else c = 8'($urandom_range(8'h20, 8'h7E));
        end while (c == CH_STAR);
        return c;
    endfunction

    function automatic logic [7:0] noise_char();
        logic [7:0] c;
        do c = 8'($urandom_range(255)); while (c == CH_DOLLAR);
        return c;
    endfunction

    task automatic start_sentence();
        char_q.push_back(CH_DOLLAR);
        gen_sum   = 8'h00;
        gen_count = gen_count + 1;
    endtask

    task automatic body_char(input logic [7:0] c);
        char_q.push_back(c);
        gen_sum   = gen_sum ^ c;
        gen_count = gen_count + 1;
    endtask

    task automatic close_sentence(input int mode, input bit lower);
        logic [7:0] s;
        logic [7:0] flip;
        flip = 8'($urandom_range(1, 255));
        s    = (mode == SUM_WRONG) ? (gen_sum ^ flip) : gen_sum;
        char_q.push_back(CH_STAR);
        if (mode == SUM_BAD_HI) begin
            char_q.push_back(bad_hex_char());
            gen_count = gen_count + 2;
        end else begin
            char_q.push_back(hex_char(s[7:4], lower));
            if (mode == SUM_BAD_LO) char_q.push_back(bad_hex_char());
            else char_q.push_back(hex_char(s[3:0], lower));
            gen_count = gen_count + 3;
        end
    endtask

    task automatic random_sentence();
        int sel;
        int pat;
        int nhdr;
        int miss;
        int tail;
        int k;
        int r;
        sel  = $urandom_range(4);
        pat  = (sel == 3) ? $urandom_range(2) : sel;
        nhdr = ($urandom_range(7) == 0) ? $urandom_range(HEADER_LEN - 1) : HEADER_LEN;
        miss = $urandom_range(HEADER_LEN - 1);
        tail = ($urandom_range(24) == 0) ? $urandom_range(115, 140) : $urandom_range(15);
        r    = $urandom_range(9);
        start_sentence();
        for (k = 0; k < nhdr; k++) begin
            if (sel == 4 || (sel == 3 && k == miss)) body_char(any_data_char());
            else body_char(header_byte(pat, k));
        end
        for (k = 0; k < tail; k++) body_char(any_data_char());
        close_sentence((r < 6) ? SUM_GOOD : (r < 8) ? SUM_WRONG : (r == 8) ? SUM_BAD_HI :
                       SUM_BAD_LO, $urandom_range(1));
    endtask

    // sender: offers queued characters, predicts each accepted request
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            reset_predictor();
        end else begin
            if (s_valid && s_ready) begin
                expected_results.push_back(predict_char(s_rx_char));
                n_sent++;
            end
            if (n_sent == PAUSE_AT && expected_results.size() == 0) pause_done = 1'b1;
            if (!s_valid || s_ready) begin
                if (char_q.size() != 0 && (n_sent != PAUSE_AT || pause_done) &&
                    $urandom_range(99) >= ((n_sent < STAGE_LEN) ? 34 :
                                           (n_sent < 2 * STAGE_LEN) ? 87 : 0)) begin
                    s_rx_char <= char_q.pop_front();
                    s_valid   <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each accepted result request against the oldest prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                mon_got = {m_sentence_start, m_data_valid, m_data_char, m_data_index,
                           m_status, m_sentence_kind, m_computed_sum, m_received_sum};
                if (expected_results.size() == 0) begin
                    if (n_errors < MAX_REPORTS)
                        $display("unexpected result %0d: start=%0d valid=%0d char=%h idx=%0d",
                                 n_recv, mon_got.sentence_start, mon_got.data_valid,
                                 mon_got.data_char, mon_got.data_index);
                    n_errors++;
                end else begin
                    mon_want = expected_results.pop_front();
                    if (mon_got !== mon_want) begin
                        if (n_errors < MAX_REPORTS)
                            $display({"mismatch at result %0d: expected start=%0d valid=%0d ",
                                      "char=%h idx=%0d status=%0d kind=%0d csum=%h rsum=%h, ",
                                      "got start=%0d valid=%0d char=%h idx=%0d status=%0d ",
                                      "kind=%0d csum=%h rsum=%h"},
                                     n_recv, mon_want.sentence_start, mon_want.data_valid,
                                     mon_want.data_char, mon_want.data_index, mon_want.status,
                                     mon_want.sentence_kind, mon_want.computed_sum,
                                     mon_want.received_sum, mon_got.sentence_start,
                                     mon_got.data_valid, mon_got.data_char, mon_got.data_index,
                                     mon_got.status, mon_got.sentence_kind,
                                     mon_got.computed_sum, mon_got.received_sum);
                        n_errors++;
                    end
                end
                n_recv++;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (n_recv >= HOLD_AT && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= ((n_recv < STAGE_LEN) ? 87 :
                                                   (n_recv < 2 * STAGE_LEN) ? 34 : 0));
            end
        end
    end

    initial begin
        // idle noise at both ends of the byte range
        char_q.push_back(8'h00);
        char_q.push_back(8'hFF);
        // well-formed gga with upper-case digits
        start_sentence();
        body_char(CH_G); body_char(CH_P); body_char(CH_G); body_char(CH_G); body_char(CH_A);
        close_sentence(SUM_GOOD, 1'b0);
        // rmc with a wrong lower-case checksum
        start_sentence();
        body_char(CH_G); body_char(CH_P); body_char(CH_R); body_char(CH_M); body_char(CH_C);
        close_sentence(SUM_WRONG, 1'b1);
        // short sentence, dollar as data, abort on first digit
        start_sentence();
        body_char(CH_G); body_char(CH_DOLLAR);
        close_sentence(SUM_BAD_HI, 1'b0);

        while (gen_count < ITEMS) begin
            repeat ($urandom_range(2)) char_q.push_back(noise_char());
            random_sentence();
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        while (char_q.size() != 0 || s_valid) @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (n_errors == 0 && expected_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

[files.f]
src/nscd_pkg.sv
src/nscd_step.sv
src/nscd_out_buf.sv
src/nmea_sentence_checksum_deframer_core.sv
tb/sv/tb_nmea_sentence_checksum_deframer_core.sv
